// ===== hdl/btd_pkg.sv =====
// Shared types, register indexes and result codes for the bignum term decoder.
`default_nettype none

package btd_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W  = 88;

	// register indexes on the configuration channel
	localparam logic [CFG_INDEX_W-1:0] REG_SMALL_TAG       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LARGE_TAG       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_LENGTH = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE_ENABLE  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_DIGIT   = 2'd0;
	localparam logic [1:0] ST_END     = 2'd1;
	localparam logic [1:0] ST_BAD_TAG = 2'd2;
	localparam logic [1:0] ST_LEN_ERR = 2'd3;

	typedef struct packed {
		logic [7:0]  small_tag;
		logic [7:0]  large_tag;
		logic [31:0] expected_length;
		logic        capture_enable;
	} btd_cfg_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] digit_value;
		logic [30:0] digit_position;
		logic [7:0]  sign_value;
		logic [32:0] consumed_bytes;
		logic        last;
	} btd_result_t;

endpackage

`default_nettype wire

// ===== hdl/btd_cfg_regs.sv =====
// Configuration register file of the bignum term decoder.
`default_nettype none

module btd_cfg_regs
	import btd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output btd_cfg_t                    cfg
);

	btd_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.small_tag       <= 8'd110;
			cfg_q.large_tag       <= 8'd111;
			cfg_q.expected_length <= '0;
			cfg_q.capture_enable  <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SMALL_TAG:       cfg_q.small_tag       <= cfg_data[7:0];
				REG_LARGE_TAG:       cfg_q.large_tag       <= cfg_data[7:0];
				REG_EXPECTED_LENGTH: cfg_q.expected_length <= cfg_data[31:0];
				REG_CAPTURE_ENABLE:  cfg_q.capture_enable  <= cfg_data[0];
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/btd_in_stage.sv =====
// Input register stage: holds one accepted byte until the decoder takes it.
`default_nettype none

module btd_in_stage
	import btd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       take,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// refill in the same cycle the held byte is consumed
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/btd_fsm.sv =====
// Term parser: state registers and the per-byte update that produces a result.
`default_nettype none

module btd_fsm
	import btd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire btd_cfg_t   cfg,
	input  wire logic       fire,
	input  wire logic [7:0] data_byte,
	output logic            emit,
	output btd_result_t     res
);

	localparam logic [1:0] PH_TAG   = 2'd0;
	localparam logic [1:0] PH_LEN   = 2'd1;
	localparam logic [1:0] PH_SIGN  = 2'd2;
	localparam logic [1:0] PH_DIGIT = 2'd3;

	logic [1:0]  phase_q,    phase_n;
	logic [1:0]  len_left_q, len_left_n;
	logic [31:0] len_acc_q,  len_acc_n;
	logic [31:0] dig_left_q, dig_left_n;
	logic [7:0]  low_hold_q, low_hold_n;
	logic        parity_q,   parity_n;
	logic [30:0] dig_cnt_q,  dig_cnt_n;
	logic [7:0]  sign_q,     sign_n;
	logic [32:0] consumed_q, consumed_n;

	logic [32:0] consumed_inc;
	logic [31:0] acc_shift;
	logic        final_byte;

	assign consumed_inc = consumed_q + 33'd1;
	assign acc_shift    = {len_acc_q[23:0], data_byte};
	assign final_byte   = (dig_left_q == 32'd1);

	always_comb begin
		phase_n    = phase_q;
		len_left_n = len_left_q;
		len_acc_n  = len_acc_q;
		dig_left_n = dig_left_q;
		low_hold_n = low_hold_q;
		parity_n   = parity_q;
		dig_cnt_n  = dig_cnt_q;
		sign_n     = sign_q;
		consumed_n = consumed_q;
		emit       = 1'b0;
		res        = '0;

		unique case (phase_q)
			PH_LEN: begin
				consumed_n = consumed_inc;
				len_acc_n  = acc_shift;
				res.consumed_bytes = consumed_inc;
				if (len_left_q != 2'd0) begin
					len_left_n = len_left_q - 2'd1;
				end else if (cfg.capture_enable && acc_shift != cfg.expected_length) begin
					phase_n    = PH_TAG;
					emit       = 1'b1;
					res.status = ST_LEN_ERR;
					res.last   = 1'b1;
				end else begin
					phase_n = PH_SIGN;
				end
			end
			PH_SIGN: begin
				consumed_n = consumed_inc;
				sign_n     = data_byte;
				dig_left_n = len_acc_q;
				parity_n   = 1'b0;
				dig_cnt_n  = '0;
				low_hold_n = '0;
				res.consumed_bytes = consumed_inc;
				if (len_acc_q == 32'd0) begin
					phase_n        = PH_TAG;
					emit           = 1'b1;
					res.status     = ST_END;
					res.sign_value = data_byte;
					res.last       = 1'b1;
				end else begin
					phase_n = PH_DIGIT;
				end
			end
			PH_DIGIT: begin
				consumed_n = consumed_inc;
				dig_left_n = dig_left_q - 32'd1;
				res.consumed_bytes = consumed_inc;
				res.sign_value     = sign_q;
				if (final_byte) begin
					phase_n = PH_TAG;
				end
				if (!cfg.capture_enable) begin
					// skip mode: count bytes, report only the end
					parity_n = !parity_q;
					if (final_byte) begin
						emit       = 1'b1;
						res.status = ST_END;
						res.last   = 1'b1;
					end
				end else if (!parity_q) begin
					low_hold_n = data_byte;
					parity_n   = 1'b1;
					if (final_byte) begin
						// odd tail byte: high byte of the digit is zero
						dig_cnt_n          = dig_cnt_q + 31'd1;
						emit               = 1'b1;
						res.status         = ST_DIGIT;
						res.digit_value    = {8'd0, data_byte};
						res.digit_position = dig_cnt_q;
						res.last           = 1'b1;
					end
				end else begin
					parity_n           = 1'b0;
					dig_cnt_n          = dig_cnt_q + 31'd1;
					emit               = 1'b1;
					res.status         = ST_DIGIT;
					res.digit_value    = {data_byte, low_hold_q};
					res.digit_position = dig_cnt_q;
					res.last           = final_byte;
				end
			end
			PH_TAG: begin
				consumed_n = 33'd1;
				len_acc_n  = '0;
				dig_cnt_n  = '0;
				parity_n   = 1'b0;
				sign_n     = '0;
				// small form wins when both tags match
				priority if (data_byte == cfg.small_tag) begin
					len_left_n = 2'd0;
					phase_n    = PH_LEN;
				end else if (data_byte == cfg.large_tag) begin
					len_left_n = 2'd3;
					phase_n    = PH_LEN;
				end else begin
					phase_n            = PH_TAG;
					emit               = 1'b1;
					res.status         = ST_BAD_TAG;
					res.consumed_bytes = 33'd1;
					res.last           = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG;
			len_left_q <= '0;
			len_acc_q  <= '0;
			dig_left_q <= '0;
			low_hold_q <= '0;
			parity_q   <= 1'b0;
			dig_cnt_q  <= '0;
			sign_q     <= '0;
			consumed_q <= '0;
		end else if (fire) begin
			phase_q    <= phase_n;
			len_left_q <= len_left_n;
			len_acc_q  <= len_acc_n;
			dig_left_q <= dig_left_n;
			low_hold_q <= low_hold_n;
			parity_q   <= parity_n;
			dig_cnt_q  <= dig_cnt_n;
			sign_q     <= sign_n;
			consumed_q <= consumed_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/btd_out_reg.sv =====
// Result register: holds one result transaction until the receiver takes it.
`default_nettype none

module btd_out_reg
	import btd_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire btd_result_t   res,
	output logic               space,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]         m_tuser,
	output logic               m_tlast
);

	btd_result_t res_q;

	// free when empty or drained this cycle
	assign space    = !m_tvalid || m_tready;
	assign m_tdata  = {res_q.consumed_bytes, res_q.sign_value,
	                   res_q.digit_position, res_q.digit_value};
	assign m_tuser  = res_q.status;
	assign m_tlast  = res_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bignum_term_decoder_core.sv =====
// Bignum term decoder: parses tagged big integer terms into 16-bit digits.
//
// Input stream s_*: one byte of the serialized term per transaction.
// Output stream m_*: at most one result per input byte. m_tuser carries the
// status (digit, end, bad tag, length mismatch), m_tlast marks the final result
// of a term or an error. Bytes that end no digit, term or error give no result.
// Configuration channel cfg_*: always ready; write only while the block is idle.
// Index 0 small tag, 1 large tag, 2 expected length, 3 capture enable.
//
// Throughput is one byte per cycle while the result register has space. A byte
// is held in the input register, then the parser updates its state and the
// result register together; the result register drives m_*.
// When the receiver stalls, the result register holds and the input register
// still takes one more byte; s_tready drops only when both are full.
// Reset clears the parser to wait for a tag, drops all pending results and
// restores the register defaults (tags 110 and 111, length 0, capture on).
`default_nettype none

module bignum_term_decoder_core
	import btd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [7:0]             s_tdata,   // data_byte
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// digit_value, digit_position, sign_value, consumed_bytes
	output logic [OUT_DATA_W-1:0]       m_tdata,
	output logic [1:0]                  m_tuser,   // status
	output logic                        m_tlast,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	btd_cfg_t    cfg;
	btd_result_t res;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        space;
	logic        fire;
	logic        emit;

	assign fire = valid_s1 && space;

	btd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	btd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (fire),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	btd_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (fire),
		.data_byte (byte_s1),
		.emit      (emit),
		.res       (res)
	);

	btd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire && emit),
		.res      (res),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== hdl/btd_checker.sv =====
// Port-level checker for the bignum term decoder, bound to the top level.
`default_nettype none

module btd_checker
	import btd_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_DATA_W-1:0]  m_tdata,
	input wire logic [1:0]             m_tuser,
	input wire logic                   m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_nondigit_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_DIGIT |-> m_tlast)
		else $error("end or error result without last");

	a_bad_tag_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_BAD_TAG |-> m_tdata[87:55] == 33'd1 && m_tdata[54:0] == '0)
		else $error("bad tag result must report one byte and no digit");

	a_len_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_LEN_ERR |->
		m_tdata[87:55] == 33'd2 || m_tdata[87:55] == 33'd5)
		else $error("length mismatch after wrong byte count");

endmodule

bind bignum_term_decoder_core btd_checker u_btd_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the bignum term decoder core with a byte-level predictor.
`timescale 1ns / 100ps

module testbench;
	import btd_pkg::*;

	localparam int unsigned RANDOM_BYTES   = 800;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	typedef enum logic [2:0] {
		PH_TAG   = 3'd0,
		PH_LEN   = 3'd1,
		PH_SIGN  = 3'd2,
		PH_DIGIT = 3'd3
	} term_phase_e;

	typedef logic [7:0] byte_q_t[$];

	class term_tracker;
		btd_result_t awaited_results[$];
		int unsigned fail_count;
		logic [7:0]  small_tag;
		logic [7:0]  large_tag;
		logic [31:0] expected_length;
		logic        capture_enable;
		term_phase_e phase;
		logic [1:0]  len_left;
		logic [31:0] len_acc;
		logic [31:0] digits_left;
		logic [7:0]  low_hold;
		logic [7:0]  sign_hold;
		logic        parity;
		logic [30:0] digit_count;
		logic [32:0] consumed;

		function new();
			fail_count      = 0;
			small_tag       = 8'd110;
			large_tag       = 8'd111;
			expected_length = 32'd0;
			capture_enable  = 1'b1;
			phase           = PH_TAG;
			len_left        = '0;
			len_acc         = '0;
			digits_left     = '0;
			low_hold        = '0;
			sign_hold       = '0;
			parity          = 1'b0;
			digit_count     = '0;
			consumed        = '0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_SMALL_TAG:       small_tag = data[7:0];
				REG_LARGE_TAG:       large_tag = data[7:0];
				REG_EXPECTED_LENGTH: expected_length = data;
				REG_CAPTURE_ENABLE:  capture_enable = data[0];
				default: ;
			endcase
		endfunction

		// Advance the parser by one byte; queue the result it causes, if any.
		function void take_byte(logic [7:0] b);
			btd_result_t r;
			bit          has_result;
			bit          last_byte;
			r = '0;
			has_result = 0;
			case (phase)
				PH_LEN: begin
					consumed = consumed + 33'd1;
					len_acc = {len_acc[23:0], b};
					if (len_left != 2'd0) begin
						len_left = len_left - 2'd1;
					end else if (capture_enable && len_acc != expected_length) begin
						phase = PH_TAG;
						r.status = ST_LEN_ERR;
						r.last = 1'b1;
						has_result = 1;
					end else begin
						phase = PH_SIGN;
					end
				end
				PH_SIGN: begin
					consumed = consumed + 33'd1;
					sign_hold = b;
					digits_left = len_acc;
					parity = 1'b0;
					digit_count = '0;
					low_hold = '0;
					if (digits_left == 32'd0) begin
						phase = PH_TAG;
						r.status = ST_END;
						r.sign_value = sign_hold;
						r.last = 1'b1;
						has_result = 1;
					end else begin
						phase = PH_DIGIT;
					end
				end
				PH_DIGIT: begin
					last_byte = (digits_left == 32'd1);
					consumed = consumed + 33'd1;
					digits_left = digits_left - 32'd1;
					if (last_byte)
						phase = PH_TAG;
					if (!capture_enable) begin
						// skip mode: track parity and the byte count, report only the end
						parity = ~parity;
						if (last_byte) begin
							r.status = ST_END;
							r.sign_value = sign_hold;
							r.last = 1'b1;
							has_result = 1;
						end
					end else if (!parity) begin
						low_hold = b;
						parity = 1'b1;
						if (last_byte) begin
							// odd final byte: high half of the digit is zero
							r.status = ST_DIGIT;
							r.digit_value = {8'h00, low_hold};
							r.digit_position = digit_count;
							r.sign_value = sign_hold;
							r.last = 1'b1;
							digit_count = digit_count + 31'd1;
							has_result = 1;
						end
					end else begin
						r.status = ST_DIGIT;
						r.digit_value = {b, low_hold};
						r.digit_position = digit_count;
						r.sign_value = sign_hold;
						r.last = last_byte;
						parity = 1'b0;
						digit_count = digit_count + 31'd1;
						has_result = 1;
					end
				end
				default: begin
					consumed = 33'd1;
					len_acc = '0;
					digit_count = '0;
					parity = 1'b0;
					sign_hold = '0;
					if (b == small_tag) begin
						len_left = 2'd0;
						phase = PH_LEN;
					end else if (b == large_tag) begin
						len_left = 2'd3;
						phase = PH_LEN;
					end else begin
						phase = PH_TAG;
						r.status = ST_BAD_TAG;
						r.last = 1'b1;
						has_result = 1;
					end
				end
			endcase
			if (has_result) begin
				r.consumed_bytes = consumed;
				awaited_results.push_back(r);
			end
		endfunction

		function void compare_field(string name, logic [32:0] want, logic [32:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				fail_count++;
			end
		endfunction

		function void match_result(logic [1:0] status, logic [OUT_DATA_W-1:0] data,
				logic last);
			btd_result_t want;
			if (awaited_results.size() == 0) begin
				$error("result with nothing awaited: status %0d data %0h last %0b",
					status, data, last);
				fail_count++;
				return;
			end
			want = awaited_results.pop_front();
			compare_field("status", 33'(want.status), 33'(status));
			compare_field("digit_value", 33'(want.digit_value), 33'(data[15:0]));
			compare_field("digit_position", 33'(want.digit_position), 33'(data[46:16]));
			compare_field("sign_value", 33'(want.sign_value), 33'(data[54:47]));
			compare_field("consumed_bytes", want.consumed_bytes, data[87:55]);
			compare_field("last", 33'(want.last), 33'(last));
		endfunction

		function void check_leftovers();
			if (awaited_results.size() != 0) begin
				$error("%0d awaited results never arrived", awaited_results.size());
				fail_count++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	term_tracker tracker = new();
	bit          send_calm = 0;
	int unsigned sent_count = 0;
	int unsigned idle_cycles = 0;

	bignum_term_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int draw_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Observe every transaction on all three channels.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				tracker.take_byte(s_tdata);
			if (m_tvalid && m_tready)
				tracker.match_result(m_tuser, m_tdata, m_tlast);
			if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Result sink with random backpressure.
	initial begin
		int  run;
		int  gap;
		bit  calm;
		calm = 0;
		@(posedge clk iff arst_n);
		forever begin
			if ($urandom_range(0, 19) == 0)
				calm = ~calm;
			run = $urandom_range(1, 30);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = draw_gap(calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	task automatic send_range(input byte_q_t q, input int from, input int upto);
		for (int i = from; i < upto; i++)
			send_byte(q[i]);
	endtask

	// Hold the input low until every awaited result is back and the pipe is empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic cfg_done();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] st, input logic [7:0] lt,
			input logic [31:0] el, input logic ce);
		drain();
		write_reg(REG_SMALL_TAG, {24'd0, st});
		write_reg(REG_LARGE_TAG, {24'd0, lt});
		write_reg(REG_EXPECTED_LENGTH, el);
		write_reg(REG_CAPTURE_ENABLE, {31'd0, ce});
		cfg_done();
	endtask

	function automatic logic [7:0] pick_sign();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return 8'h00;
		if (r < 40)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	initial begin
		byte_q_t     q;
		logic [7:0]  st;
		logic [7:0]  lt;
		logic [31:0] el;
		logic        ce;
		logic [31:0] len;
		logic [7:0]  b;
		int          r;
		int          kind;
		int          n_terms;
		int          head;
		int          split;
		bit          use_large;
		int unsigned random_start;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bad tags, empty term, length mismatch on the large form.
		q = '{8'h00, 8'hFF, 8'd110, 8'h00, 8'h80, 8'd111, 8'h00, 8'h00, 8'h00, 8'h01};
		send_range(q, 0, q.size());
		// Even digit pair then an odd final byte.
		set_config(8'd110, 8'd111, 32'd3, 1'b1);
		q = '{8'd110, 8'h03, 8'hFF, 8'h12, 8'hFE, 8'hAB};
		send_range(q, 0, q.size());
		// Equal tags at the top extreme: the small form wins.
		set_config(8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
		q = '{8'hFF, 8'h05, 8'h00};
		send_range(q, 0, q.size());
		// Skip mode with the large form.
		set_config(8'h00, 8'hFF, 32'd0, 1'b0);
		q = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h55, 8'hAA};
		send_range(q, 0, q.size());

		random_start = sent_count;
		while (sent_count - random_start < RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			st = (r < 15) ? 8'h00 : (r < 30) ? 8'hFF : 8'($urandom);
			r = $urandom_range(0, 99);
			lt = (r < 12) ? st : (r < 20) ? 8'h00 : (r < 28) ? 8'hFF : 8'($urandom);
			ce = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			el = (r < 8) ? 32'hFFFF_FFFF : (r < 16) ? $urandom : $urandom_range(0, 12);
			set_config(st, lt, el, ce);
			send_calm = ($urandom_range(0, 3) == 0);
			n_terms = $urandom_range(3, 10);
			repeat (n_terms) begin
				q.delete();
				split = 0;
				kind = $urandom_range(0, 99);
				if (kind < 80 && ce && el > 32'd16)
					kind = 85;
				use_large = $urandom_range(0, 1) && (st != lt);
				if (kind < 80) begin
					// well-formed term with random content
					len = ce ? el : $urandom_range(0, 12);
					if (use_large) begin
						q.push_back(lt);
						q.push_back(len[31:24]);
						q.push_back(len[23:16]);
						q.push_back(len[15:8]);
						q.push_back(len[7:0]);
					end else begin
						q.push_back(st);
						q.push_back(len[7:0]);
					end
					head = q.size();
					q.push_back(pick_sign());
					for (int i = 0; i < int'(len); i++)
						q.push_back(8'($urandom));
					if (len >= 32'd2 && $urandom_range(0, 99) < 12)
						split = head + 1 + $urandom_range(1, int'(len) - 1);
				end else if (kind < 92 && ce) begin
					// header whose length disagrees with the expected length
					if (use_large) begin
						do len = $urandom; while (len == el);
						q.push_back(lt);
						q.push_back(len[31:24]);
						q.push_back(len[23:16]);
						q.push_back(len[15:8]);
						q.push_back(len[7:0]);
					end else begin
						do b = 8'($urandom); while ({24'd0, b} == el);
						q.push_back(st);
						q.push_back(b);
					end
				end else begin
					// noise: bytes that match neither tag
					repeat ($urandom_range(1, 4)) begin
						do b = 8'($urandom); while (b == st || b == lt);
						q.push_back(b);
					end
				end
				if (split > 0) begin
					// flip capture mode in the middle of the digit bytes
					send_range(q, 0, split);
					drain();
					ce = ~ce;
					write_reg(REG_CAPTURE_ENABLE, {31'd0, ce});
					cfg_done();
					send_range(q, split, q.size());
				end else begin
					send_range(q, 0, q.size());
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		tracker.check_leftovers();
		if (tracker.fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
